// File: sv/slce_pkg.sv
// ----------------------------------------------------------------------------
// Sound log command encoder package
// Op codes, command-stream byte codes, wait classes, controller states and
// the command/status structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package slce_pkg;

   // Input op codes
   typedef enum logic [2:0] {
      OP_START  = 3'd0,
      OP_WRITE1 = 3'd1,
      OP_WRITE2 = 3'd2,
      OP_ELAPSE = 3'd3,
      OP_STOP   = 3'd4
   } op_type;

   // Command-stream byte codes
   localparam logic [7:0] CODE_END        = 8'h66;
   localparam logic [7:0] CODE_WRITE1     = 8'h50;
   localparam logic [7:0] CODE_WRITE2     = 8'hA0;
   localparam logic [7:0] CODE_WAIT_735   = 8'h62;
   localparam logic [7:0] CODE_WAIT_882   = 8'h63;
   localparam logic [7:0] CODE_WAIT_SHORT = 8'h70;
   localparam logic [7:0] CODE_WAIT_LONG  = 8'h61;

   // Wait lengths with dedicated coding
   localparam int unsigned WAIT_NTSC      = 735;
   localparam int unsigned WAIT_PAL       = 882;
   localparam int unsigned WAIT_SHORT_MAX = 16;
   localparam int unsigned WAIT_CHUNK     = 65535;

   // How the pending wait will be coded next
   typedef enum logic [2:0] {
      WC_ZERO,
      WC_735,
      WC_882,
      WC_SHORT,
      WC_MID,
      WC_BIG
   } wait_class_type;

   // Which byte the datapath loads into the output register
   typedef enum logic [3:0] {
      SEL_NONE,
      SEL_W735,
      SEL_W882,
      SEL_WSHORT,
      SEL_W61,
      SEL_WLO,
      SEL_WHI,
      SEL_WR1,
      SEL_WR2,
      SEL_REG,
      SEL_DATA,
      SEL_END
   } byte_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_WAIT_LO,
      ST_WAIT_HI,
      ST_CMD0,
      ST_CMD1,
      ST_CMD2
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  reg_req;
      logic [7:0]  data;
      logic [15:0] elapsed;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last;
      logic        stream_end;
      logic [31:0] sample_total;
      logic        first_chip_used;
      logic        second_chip_used;
   } rsp_item_type;

   // Controller -> datapath
   typedef struct packed {
      logic         capture;
      logic         start;
      logic         elapse;
      logic         wait_take;
      byte_sel_type emit_sel;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      op_type         cur_op;
      logic           recording;
      wait_class_type wclass;
      logic           slot_free;
   } sts_type;

endpackage

// File: sv/slce_if.sv
// ----------------------------------------------------------------------------
// Sound log command encoder channels
// Valid/ready channels for request items and for command-stream byte items.
// ----------------------------------------------------------------------------
interface slce_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [7:0]  reg_req;
   logic [7:0]  data;
   logic [15:0] elapsed;

   modport source (output valid, op, reg_req, data, elapsed, input ready);
   modport sink (input valid, op, reg_req, data, elapsed, output ready);
endinterface

interface slce_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last;
   logic        stream_end;
   logic [31:0] sample_total;
   logic        first_chip_used;
   logic        second_chip_used;

   modport source (output valid, out_byte, last, stream_end, sample_total,
                   first_chip_used, second_chip_used, input ready);
   modport sink (input valid, out_byte, last, stream_end, sample_total,
                 first_chip_used, second_chip_used, output ready);
endinterface

// File: sv/slce_datapath.sv
// ----------------------------------------------------------------------------
// Sound log command encoder datapath
// Recording state, wait and sample counters, usage flags, captured request
// and the output byte register.
// ----------------------------------------------------------------------------
module slce_datapath
   import slce_pkg::*;
#(
   parameter int WAIT_WIDTH = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  cmd_type      cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         rsp_ready
);

   logic                  recording_ff, recording_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [31:0]           total_ff, total_in;
   logic                  first_ff, first_in;
   logic                  second_ff, second_in;
   op_type                op_ff;
   logic [7:0]            reg_ff;
   logic [7:0]            data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_ff, rsp_in;

   logic [WAIT_WIDTH:0]   wait_sum;
   wait_class_type        wclass;
   logic                  slot_free;
   logic [7:0]            emit_byte;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign wait_sum  = {1'b0, wait_ff} + (WAIT_WIDTH+1)'(req_item.elapsed);

   always_comb begin
      if (wait_ff == '0) begin
         wclass = WC_ZERO;
      end else if (wait_ff == WAIT_WIDTH'(WAIT_NTSC)) begin
         wclass = WC_735;
      end else if (wait_ff == WAIT_WIDTH'(WAIT_PAL)) begin
         wclass = WC_882;
      end else if (wait_ff <= WAIT_WIDTH'(WAIT_SHORT_MAX)) begin
         wclass = WC_SHORT;
      end else if (wait_ff <= WAIT_WIDTH'(WAIT_CHUNK)) begin
         wclass = WC_MID;
      end else begin
         wclass = WC_BIG;
      end
   end

   // short wait is 1..16, so the code is base + n - 1
   always_comb begin
      unique case (cmd.emit_sel)
         SEL_W735:   emit_byte = CODE_WAIT_735;
         SEL_W882:   emit_byte = CODE_WAIT_882;
         SEL_WSHORT: emit_byte = CODE_WAIT_SHORT + {3'b000, wait_ff[4:0]} - 8'd1;
         SEL_W61:    emit_byte = CODE_WAIT_LONG;
         SEL_WLO:    emit_byte = (wclass == WC_BIG) ? 8'hFF : wait_ff[7:0];
         SEL_WHI:    emit_byte = (wclass == WC_BIG) ? 8'hFF : wait_ff[15:8];
         SEL_WR1:    emit_byte = CODE_WRITE1;
         SEL_WR2:    emit_byte = CODE_WRITE2;
         SEL_REG:    emit_byte = reg_ff;
         SEL_DATA:   emit_byte = data_ff;
         SEL_END:    emit_byte = CODE_END;
         default:    emit_byte = 8'h00;
      endcase
   end

   always_comb begin
      recording_in = recording_ff;
      wait_in      = wait_ff;
      total_in     = total_ff;
      first_in     = first_ff;
      second_in    = second_ff;

      if (cmd.start) begin
         recording_in = 1'b1;
         wait_in      = '0;
         total_in     = '0;
         first_in     = 1'b0;
         second_in    = 1'b0;
      end
      if (cmd.elapse) begin
         wait_in  = wait_sum[WAIT_WIDTH] ? '1 : wait_sum[WAIT_WIDTH-1:0];
         total_in = total_ff + 32'(req_item.elapsed);
      end
      if (cmd.wait_take) begin
         wait_in = (wclass == WC_BIG) ? wait_ff - WAIT_WIDTH'(WAIT_CHUNK) : '0;
      end
      if (cmd.emit_sel == SEL_WR1) begin
         first_in = 1'b1;
      end
      if (cmd.emit_sel == SEL_WR2) begin
         second_in = 1'b1;
      end
      if (cmd.emit_sel == SEL_END) begin
         recording_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit_sel != SEL_NONE) begin
         rsp_valid_in            = 1'b1;
         rsp_in.out_byte         = emit_byte;
         rsp_in.last             = (cmd.emit_sel == SEL_DATA) || (cmd.emit_sel == SEL_END);
         rsp_in.stream_end       = (cmd.emit_sel == SEL_END);
         rsp_in.sample_total     = (cmd.emit_sel == SEL_END) ? total_ff : 32'd0;
         rsp_in.first_chip_used  = (cmd.emit_sel == SEL_END) && first_ff;
         rsp_in.second_chip_used = (cmd.emit_sel == SEL_END) && second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff <= 1'b0;
         wait_ff      <= '0;
         total_ff     <= '0;
         first_ff     <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         recording_ff <= recording_in;
         wait_ff      <= wait_in;
         total_ff     <= total_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         op_ff   <= req_item.op;
         reg_ff  <= req_item.reg_req;
         data_ff <= req_item.data;
      end
   end

   assign sts.cur_op    = op_ff;
   assign sts.recording = recording_ff;
   assign sts.wclass    = wclass;
   assign sts.slot_free = slot_free;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_ff;

`ifndef SYNTHESIS
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stream_end |-> rsp_ff.last)
      else $error("end-of-data item without last");

   a_stop_only_at_end: assert property (@(posedge clock) disable iff (reset)
      $fell(recording_ff) && !$past(reset) |-> $past(cmd.emit_sel == SEL_END))
      else $error("recording ended without end-of-data byte");

   a_summary_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.stream_end |->
         rsp_ff.sample_total == 32'd0 && !rsp_ff.first_chip_used &&
         !rsp_ff.second_chip_used)
      else $error("summary fields set on a non-final byte");
`endif

endmodule

// File: sv/slce_ctrl.sv
// ----------------------------------------------------------------------------
// Sound log command encoder controller
// Sequences the wait flush and the command bytes of one request item.
// ----------------------------------------------------------------------------
module slce_ctrl
   import slce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  op_type  req_op,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && sts.recording &&
                (req_op == OP_WRITE1 || req_op == OP_WRITE2 || req_op == OP_STOP)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (sts.wclass == WC_ZERO) begin
               state_in = ST_CMD0;
            end else if (sts.slot_free &&
                         (sts.wclass == WC_MID || sts.wclass == WC_BIG)) begin
               state_in = ST_WAIT_LO;
            end
         end
         ST_WAIT_LO: if (sts.slot_free) state_in = ST_WAIT_HI;
         ST_WAIT_HI: if (sts.slot_free) state_in = ST_FLUSH;
         ST_CMD0: begin
            if (sts.slot_free) begin
               state_in = (sts.cur_op == OP_STOP) ? ST_IDLE : ST_CMD1;
            end
         end
         ST_CMD1: begin
            if (sts.slot_free) begin
               state_in = (sts.cur_op == OP_WRITE2) ? ST_CMD2 : ST_IDLE;
            end
         end
         ST_CMD2: if (sts.slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.start     = 1'b0;
      cmd.elapse    = 1'b0;
      cmd.wait_take = 1'b0;
      cmd.emit_sel  = SEL_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = accept;
            cmd.start   = accept && (req_op == OP_START) && !sts.recording;
            cmd.elapse  = accept && (req_op == OP_ELAPSE) && sts.recording;
         end
         ST_FLUSH: begin
            if (sts.slot_free) begin
               unique case (sts.wclass)
                  WC_735: begin
                     cmd.emit_sel  = SEL_W735;
                     cmd.wait_take = 1'b1;
                  end
                  WC_882: begin
                     cmd.emit_sel  = SEL_W882;
                     cmd.wait_take = 1'b1;
                  end
                  WC_SHORT: begin
                     cmd.emit_sel  = SEL_WSHORT;
                     cmd.wait_take = 1'b1;
                  end
                  WC_MID, WC_BIG: cmd.emit_sel = SEL_W61;
                  default: cmd.emit_sel = SEL_NONE;
               endcase
            end
         end
         ST_WAIT_LO: if (sts.slot_free) cmd.emit_sel = SEL_WLO;
         ST_WAIT_HI: begin
            if (sts.slot_free) begin
               cmd.emit_sel  = SEL_WHI;
               cmd.wait_take = 1'b1;
            end
         end
         ST_CMD0: begin
            if (sts.slot_free) begin
               unique case (sts.cur_op)
                  OP_WRITE1: cmd.emit_sel = SEL_WR1;
                  OP_WRITE2: cmd.emit_sel = SEL_WR2;
                  OP_STOP:   cmd.emit_sel = SEL_END;
                  default:   cmd.emit_sel = SEL_NONE;
               endcase
            end
         end
         ST_CMD1: begin
            if (sts.slot_free) begin
               cmd.emit_sel = (sts.cur_op == OP_WRITE2) ? SEL_REG : SEL_DATA;
            end
         end
         ST_CMD2: if (sts.slot_free) cmd.emit_sel = SEL_DATA;
         default: cmd.emit_sel = SEL_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_sel != SEL_NONE |-> sts.slot_free)
      else $error("byte emitted while output register is full");

   a_long_wait_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT_LO || state_ff == ST_WAIT_HI |->
         sts.wclass == WC_MID || sts.wclass == WC_BIG)
      else $error("long wait bytes with no long wait pending");

   a_cmd_after_flush: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMD0 |-> sts.wclass == WC_ZERO)
      else $error("command byte before wait fully flushed");
`endif

endmodule

// File: sv/sound_log_command_encoder.sv
// ----------------------------------------------------------------------------
// Sound log command encoder
// Turns chip register writes and elapsed-sample ticks into a command stream.
// ----------------------------------------------------------------------------
// One request item is handled at a time. Start, elapse, ignored ops and any
// op while not recording are accepted in the idle state and emit nothing. A
// chip write or stop is accepted, then emits its bytes (wait codes, then 2
// or 3 write bytes or the single 0x66), each once the output register is
// free, with a pass through the flush state to confirm the wait is used up;
// the byte sink can stall it. A pending wait above 65535 costs three bytes
// per 65535-sample chunk. The controller emits through a single output byte
// register; the last byte of an item may still sit there while the next
// item is accepted. The end-of-data byte carries the sample total and the
// chip usage flags; other bytes carry zeros in those fields.
// ----------------------------------------------------------------------------
module sound_log_command_encoder
   import slce_pkg::*;
#(
   parameter int WAIT_WIDTH = 20   // pending wait width, 17..32
) (
   input  logic   clock,
   input  logic   reset,
   slce_req_if.sink   req_if,
   slce_rsp_if.source rsp_if
);

   req_item_type req_item;
   rsp_item_type rsp_item;
   cmd_type      cmd;
   sts_type      sts;
   logic         req_ready;
   logic         rsp_valid;

   // unpack the request channel
   assign req_item.op      = op_type'(req_if.op);
   assign req_item.reg_req = req_if.reg_req;
   assign req_item.data    = req_if.data;
   assign req_item.elapsed = req_if.elapsed;
   assign req_if.ready     = req_ready;

   slce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_op    (req_item.op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   slce_datapath #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_if.ready)
   );

   // pack the byte channel
   assign rsp_if.valid            = rsp_valid;
   assign rsp_if.out_byte         = rsp_item.out_byte;
   assign rsp_if.last             = rsp_item.last;
   assign rsp_if.stream_end       = rsp_item.stream_end;
   assign rsp_if.sample_total     = rsp_item.sample_total;
   assign rsp_if.first_chip_used  = rsp_item.first_chip_used;
   assign rsp_if.second_chip_used = rsp_item.second_chip_used;

endmodule

// File: tb/slce_stream_checker.sv
// ----------------------------------------------------------------------------
// Sound log command encoder stream checker
// Watches both channels, predicts the command byte stream of every accepted
// request item and compares each accepted byte item field by field.
// ----------------------------------------------------------------------------
module slce_stream_checker
   import slce_pkg::*;
#(
   parameter int WAIT_WIDTH = 20
) (
   input  logic clock,
   input  logic reset,
   slce_req_if  req_if,
   slce_rsp_if  rsp_if,
   output int   fail_count,
   output int   pending_count,
   output int   bytes_checked
);

   localparam logic [WAIT_WIDTH-1:0] WAIT_FULL = '1;

   // predicted encoder state
   logic                  recording;
   logic [WAIT_WIDTH-1:0] wait_acc;
   logic [31:0]           sample_sum;
   logic                  chip1_seen;
   logic                  chip2_seen;

   rsp_item_type          stream_q[$];
   int                    fails;
   int                    checked;

   function automatic rsp_item_type plain_byte(logic [7:0] b);
      rsp_item_type r;
      r = '0;
      r.out_byte = b;
      return r;
   endfunction

   // append one predicted byte item at the tail
   task automatic enqueue_item(rsp_item_type item);
      stream_q.insert(stream_q.size(), item);
   endtask

   task automatic emit(logic [7:0] b);
      enqueue_item(plain_byte(b));
   endtask

   // code the pending wait, in chunks of at most 65535 samples
   task automatic flush_wait_codes();
      logic [WAIT_WIDTH-1:0] rem;
      rem = wait_acc;
      while (rem != 0) begin
         if (rem == WAIT_NTSC) begin
            emit(CODE_WAIT_735);
            rem = '0;
         end else if (rem == WAIT_PAL) begin
            emit(CODE_WAIT_882);
            rem = '0;
         end else if (rem <= WAIT_SHORT_MAX) begin
            emit(CODE_WAIT_SHORT + 8'(rem - 1'b1));
            rem = '0;
         end else if (rem <= WAIT_CHUNK) begin
            emit(CODE_WAIT_LONG);
            emit(rem[7:0]);
            emit(rem[15:8]);
            rem = '0;
         end else begin
            emit(CODE_WAIT_LONG);
            emit(8'hFF);
            emit(8'hFF);
            rem = rem - WAIT_WIDTH'(WAIT_CHUNK);
         end
      end
      wait_acc = '0;
   endtask

   task automatic encode_request(logic [2:0] op_raw, logic [7:0] reg_no,
                                 logic [7:0] dat, logic [15:0] el);
      int                  start_len;
      logic [WAIT_WIDTH:0] sum;
      rsp_item_type        end_byte;
      start_len = stream_q.size();
      if (op_raw == OP_START) begin
         if (!recording) begin
            recording  = 1'b1;
            wait_acc   = '0;
            sample_sum = '0;
            chip1_seen = 1'b0;
            chip2_seen = 1'b0;
         end
      end else if (recording) begin
         case (op_raw)
            OP_WRITE1: begin
               flush_wait_codes();
               chip1_seen = 1'b1;
               emit(CODE_WRITE1);
               emit(dat);
            end
            OP_WRITE2: begin
               flush_wait_codes();
               chip2_seen = 1'b1;
               emit(CODE_WRITE2);
               emit(reg_no);
               emit(dat);
            end
            OP_ELAPSE: begin
               sum        = {1'b0, wait_acc} + (WAIT_WIDTH+1)'(el);
               wait_acc   = sum[WAIT_WIDTH] ? WAIT_FULL : sum[WAIT_WIDTH-1:0];
               sample_sum = sample_sum + 32'(el);
            end
            OP_STOP: begin
               flush_wait_codes();
               end_byte                  = plain_byte(CODE_END);
               end_byte.stream_end       = 1'b1;
               end_byte.sample_total     = sample_sum;
               end_byte.first_chip_used  = chip1_seen;
               end_byte.second_chip_used = chip2_seen;
               enqueue_item(end_byte);
               recording = 1'b0;
            end
            default: ;
         endcase
         if (stream_q.size() > start_len)
            stream_q[stream_q.size()-1].last = 1'b1;
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         recording  = 1'b0;
         wait_acc   = '0;
         sample_sum = '0;
         chip1_seen = 1'b0;
         chip2_seen = 1'b0;
         stream_q.delete();
         fails      = 0;
         checked    = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            encode_request(req_if.op, req_if.reg_req, req_if.data, req_if.elapsed);
         if (rsp_if.valid && rsp_if.ready) begin
            got.out_byte         = rsp_if.out_byte;
            got.last             = rsp_if.last;
            got.stream_end       = rsp_if.stream_end;
            got.sample_total     = rsp_if.sample_total;
            got.first_chip_used  = rsp_if.first_chip_used;
            got.second_chip_used = rsp_if.second_chip_used;
            if (stream_q.size() == 0) begin
               $display("%0t: unexpected byte item, expected none, got %h",
                        $time, got);
               fails++;
            end else begin
               want = stream_q.pop_front();
               check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
               check_field("last", 32'(want.last), 32'(got.last));
               check_field("stream_end", 32'(want.stream_end), 32'(got.stream_end));
               check_field("sample_total", want.sample_total, got.sample_total);
               check_field("first_chip_used", 32'(want.first_chip_used),
                           32'(got.first_chip_used));
               check_field("second_chip_used", 32'(want.second_chip_used),
                           32'(got.second_chip_used));
               checked++;
            end
         end
      end
      fail_count    <= fails;
      pending_count <= stream_q.size();
      bytes_checked <= checked;
   end

endmodule

// File: tb/sound_log_command_encoder_tb.sv
// ----------------------------------------------------------------------------
// Sound log command encoder testbench
// Drives request items with random gaps and a randomly stalling byte sink;
// a side checker predicts and compares the command byte stream.
// ----------------------------------------------------------------------------
module sound_log_command_encoder_tb
   import slce_pkg::*;
();

   localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake at all
   localparam int RANDOM_ITEMS = 435;
   localparam int DRAIN_CYCLES = 20;     // tail after the last byte

   logic clock;
   logic reset;
   logic calm;          // 1: no idling on either side
   int   fail_count;
   int   pending_count;
   int   bytes_checked;
   int   items_sent;
   int   sessions;
   int   idle_cycles;

   slce_req_if req_ch();
   slce_rsp_if rsp_ch();

   sound_log_command_encoder #(.WAIT_WIDTH(20)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   slce_stream_checker #(.WAIT_WIDTH(20)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_ch),
      .rsp_if        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .bytes_checked (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm)
         return 0;
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Elapse amounts aimed at every wait coding and its edges.
   function automatic logic [15:0] pick_elapse();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'($urandom_range(1, WAIT_SHORT_MAX));
         2: return 16'($urandom_range(WAIT_SHORT_MAX + 1, 1000));
         3: return 16'(WAIT_NTSC);
         4: return 16'(WAIT_PAL);
         5: return 16'(WAIT_CHUNK);
         6: return 16'($urandom_range(WAIT_NTSC - 1, WAIT_NTSC + 1));
         7: return 16'($urandom_range(WAIT_PAL - 1, WAIT_PAL + 1));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Byte sink: ready drops for random stretches, changes at falling edges.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // One request item. Returns at the rising edge that accepts it; valid
   // stays up so that a back-to-back item keeps the channel busy.
   task automatic send_item(logic [2:0] op, logic [7:0] reg_no, logic [7:0] dat,
                            logic [15:0] el);
      int gap;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.reg_req <= reg_no;
      req_ch.data    <= dat;
      req_ch.elapsed <= el;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      items_sent++;
   endtask

   // Random filler for fields the op does not use.
   task automatic send_op(logic [2:0] op, logic [15:0] el);
      send_item(op, 8'($urandom), 8'($urandom), el);
   endtask

   // Any op code, any fields: covers the unused codes and stray starts/stops.
   task automatic send_noise();
      send_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                16'($urandom));
   endtask

   // Sender holds off until the checker has seen every predicted byte.
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   // Body of a recording session: mostly elapses and writes.
   task automatic send_session_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         send_op(OP_ELAPSE, pick_elapse());
      else if (r < 60)
         send_op(OP_WRITE1, 16'($urandom));
      else if (r < 80)
         send_op(OP_WRITE2, 16'($urandom));
      else if (r < 90)
         send_noise();
      else
         send_op(OP_ELAPSE, 16'($urandom_range(0, WAIT_SHORT_MAX)));
   endtask

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles, %0d bytes outstanding",
                  $time, idle_cycles, pending_count);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int base;
      reset          = 1'b1;
      calm           = 1'b0;
      items_sent     = 0;
      sessions       = 0;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_START;
      req_ch.reg_req = '0;
      req_ch.data    = '0;
      req_ch.elapsed = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // not recording yet: everything but start is dropped
      send_op(OP_STOP, 16'hFFFF);
      send_item(OP_WRITE1, 8'hFF, 8'hFF, 16'hFFFF);
      send_op(OP_ELAPSE, 16'd100);
      send_item(3'd7, 8'hFF, 8'hFF, 16'hFFFF);
      // start, then a second start while recording (ignored)
      send_op(OP_START, 16'd0);
      send_op(OP_START, 16'd0);
      // writes with no pending wait, field extremes
      send_item(OP_WRITE1, 8'h00, 8'h00, 16'h0000);
      send_item(OP_WRITE2, 8'hFF, 8'hFF, 16'h0000);
      // shortest and longest short wait
      send_op(OP_ELAPSE, 16'd1);
      send_op(OP_WRITE1, 16'd0);
      send_op(OP_ELAPSE, 16'd16);
      send_op(OP_WRITE2, 16'd0);
      // first long wait, then the two frame-rate shortcuts
      send_op(OP_ELAPSE, 16'd17);
      send_op(OP_WRITE1, 16'd0);
      send_op(OP_ELAPSE, 16'(WAIT_NTSC));
      send_op(OP_WRITE2, 16'd0);
      send_op(OP_ELAPSE, 16'(WAIT_PAL));
      send_op(OP_WRITE1, 16'd0);
      // one full chunk plus one sample: chunked wait then short code
      send_op(OP_ELAPSE, 16'hFFFF);
      send_op(OP_ELAPSE, 16'd1);
      send_op(OP_WRITE2, 16'd0);
      // unused op codes while recording
      send_noise();
      send_item(3'd5, 8'h00, 8'h00, 16'h0000);
      send_item(3'd6, 8'hAA, 8'h55, 16'h8000);
      // zero elapse, stop carries the totals and both flags
      send_op(OP_ELAPSE, 16'd0);
      send_op(OP_STOP, 16'd0);
      // after stop nothing comes out
      send_op(OP_WRITE1, 16'd0);
      drain();

      // ---- random part: sessions of mostly well-formed traffic ----
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         sessions++;
         calm = (sessions % 5 == 3);
         // strays between sessions
         repeat ($urandom_range(0, 2)) send_noise();
         send_op(OP_START, 16'($urandom));
         // now and then push the pending wait into saturation
         if ($urandom_range(0, 7) == 0)
            repeat (17) send_op(OP_ELAPSE, 16'hFFFF);
         repeat ($urandom_range(3, 20)) send_session_op();
         // most sessions end cleanly; some are left open
         if ($urandom_range(0, 9) != 0)
            send_op(OP_STOP, 16'($urandom));
         if ($urandom_range(0, 3) == 0)
            drain();
      end
      calm = 1'b0;

      // ---- wind down ----
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d request items over %0d random sessions, %0d stream bytes checked,",
               items_sent, sessions, bytes_checked);
      $display("with all wait codings, saturated waits, stalls and ignored ops.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
